// File: rtl/core/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, sampled on the rising clock edge and held off during reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must hold at every sampled edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// File: rtl/core/fcpa_pkg.sv
package fcpa_pkg;

	// Field widths of the item, result and configuration ports
	localparam int OP_W   = 2;
	localparam int IDX_W  = 8;
	localparam int CNT_W  = 9;
	localparam int STAT_W = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_RESET = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd2;

	// Pool size after reset
	localparam logic [CNT_W-1:0] POOL_CHUNKS_RST = 9'd256;

	// One free-list entry: link to the next chunk and whether that link is live
	typedef struct packed {
		logic             more;
		logic [IDX_W-1:0] link;
	} link_entry_t;

	localparam int LINK_ENTRY_W = $bits(link_entry_t);

endpackage

// File: rtl/core/fcpa_ram.sv
module fcpa_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/fixed_chunk_pool_allocator.sv
// Fixed-size chunk pool allocator.
// Command channel: an item (opcode, chunk_index) is taken on a rising edge with
// start high and busy low. Opcodes: allocate, free, reset pool.
// Result channel: done is high for exactly one cycle with status and
// granted_index; the receiver cannot hold results off.
// Flow: the accepting edge moves control to the work state; done, status and
// granted_index are registered from the work state.
// The free-list link of the current head is read from the link RAM through its
// registered read port before the item can update the head, so busy is high for
// the cycle after each accept and no new item is taken while busy.
// A new item may be taken in the same cycle that done shows the previous one.
// Configuration: cfg_valid/cfg_ready write pool_chunks (cfg_ready is always
// high); the new size takes effect at once, list and frontier are untouched.
// Reset: arst_n clears the free list, the frontier and the control state and
// sets the pool size to 256. The link RAM is not cleared; only entries written
// by a free are ever used.
`include "assert_macros.svh"

module fixed_chunk_pool_allocator #(
	parameter int MAX_CHUNKS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [fcpa_pkg::OP_W-1:0]     opcode,
	input  logic [fcpa_pkg::IDX_W-1:0]    chunk_index,
	output logic                          done,
	output logic [fcpa_pkg::STAT_W-1:0]   status,
	output logic [fcpa_pkg::IDX_W-1:0]    granted_index,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fcpa_pkg::CNT_W-1:0]    cfg_data
);

	import fcpa_pkg::*;

	localparam int RAM_DEPTH = (MAX_CHUNKS < 256) ? MAX_CHUNKS : 256;
	localparam int AW        = $clog2(RAM_DEPTH);
	localparam int CNT_CAP   = (MAX_CHUNKS < 511) ? MAX_CHUNKS : 511;
	localparam logic [CNT_W-1:0] CNT_CAP_V   = CNT_W'(CNT_CAP);
	localparam logic [CNT_W-1:0] RAM_DEPTH_V = CNT_W'(RAM_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WORK = 2'b10
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  pool_chunks_q;
	logic [OP_W-1:0]   op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  head_q;
	logic              nonempty_q;
	logic [CNT_W-1:0]  frontier_q;
	logic              done_q;
	logic [STAT_W-1:0] status_q;
	logic [IDX_W-1:0]  granted_q;

	logic              accept;
	logic              work;
	logic [CNT_W-1:0]  count;
	logic              idx_in_range;
	logic              head_in_ram;
	link_entry_t       rd_entry;
	link_entry_t       wr_entry;
	logic [LINK_ENTRY_W-1:0] rd_raw;
	logic              ram_we;

	logic [IDX_W-1:0]  head_n;
	logic              nonempty_n;
	logic [CNT_W-1:0]  frontier_n;
	logic [STAT_W-1:0] status_n;
	logic [IDX_W-1:0]  granted_n;

	assign accept    = start && (state_q == S_IDLE);
	assign work      = (state_q == S_WORK);
	assign busy      = work;
	assign cfg_ready = 1'b1;

	// Saturate the configured size to the pool capacity
	assign count        = (pool_chunks_q > CNT_CAP_V) ? CNT_CAP_V : pool_chunks_q;
	assign idx_in_range = ({1'b0, idx_q} < count);
	assign head_in_ram  = ({1'b0, head_q} < RAM_DEPTH_V);

	// Push writes the old head behind the freed chunk
	assign ram_we        = work && (op_q == OP_FREE) && idx_in_range;
	assign wr_entry.more = nonempty_q;
	assign wr_entry.link = head_q;
	assign rd_entry      = link_entry_t'(rd_raw);

	// Link RAM: the head's entry is read at accept, ready in the work cycle
	fcpa_ram #(
		.WIDTH(LINK_ENTRY_W),
		.DEPTH(RAM_DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q[AW-1:0]),
		.wdata(wr_entry),
		.re   (accept),
		.raddr(head_q[AW-1:0]),
		.rdata(rd_raw)
	);

	// Decide the operation's effect on the list, frontier and result
	always_comb begin
		head_n     = head_q;
		nonempty_n = nonempty_q;
		frontier_n = frontier_q;
		status_n   = ST_OK;
		granted_n  = '0;
		case (op_q)
			OP_ALLOC: begin
				if (nonempty_q) begin
					granted_n = head_q;
					if (head_in_ram) begin
						head_n     = rd_entry.link;
						nonempty_n = rd_entry.more;
					end else begin
						head_n     = '0;
						nonempty_n = 1'b0;
					end
				end else if (frontier_q < count) begin
					granted_n  = frontier_q[IDX_W-1:0];
					frontier_n = frontier_q + CNT_W'(1);
				end else begin
					status_n = ST_EXHAUSTED;
				end
			end
			OP_FREE: begin
				if (idx_in_range) begin
					head_n     = idx_q;
					nonempty_n = 1'b1;
				end else begin
					status_n = ST_BAD_INDEX;
				end
			end
			OP_RESET: begin
				head_n     = '0;
				nonempty_n = 1'b0;
				frontier_n = '0;
			end
			default: begin
			end
		endcase
	end

	// Sequence control, list state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pool_chunks_q <= POOL_CHUNKS_RST;
			head_q        <= '0;
			nonempty_q    <= 1'b0;
			frontier_q    <= '0;
			done_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pool_chunks_q <= cfg_data;
			end
			done_q <= work;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_WORK;
					end
				end
				S_WORK: begin
					head_q     <= head_n;
					nonempty_q <= nonempty_n;
					frontier_q <= frontier_n;
					state_q    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the accepted item and the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			idx_q <= chunk_index;
		end
		if (work) begin
			status_q  <= status_n;
			granted_q <= granted_n;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign granted_index = granted_q;

	`ASSERT_IMPL(a_accept_goes_busy, clk, arst_n, (start && !busy) |=> busy,
		"accepted item did not enter the work cycle")
	`ASSERT_IMPL(a_work_gives_done, clk, arst_n, busy |=> (done && !busy),
		"work cycle not followed by exactly one result")
	`ASSERT_IMPL(a_no_grant_on_error, clk, arst_n,
		(done && (status != ST_OK)) |-> (granted_index == '0),
		"granted index non-zero on a failed item")
	`ASSERT_ALWAYS(a_frontier_bound, clk, arst_n, frontier_q <= CNT_CAP_V,
		"frontier ran past the pool capacity")
	`ASSERT_IMPL(a_free_write_only_in_work, clk, arst_n, ram_we |-> (busy && !done),
		"link RAM written outside a free item's work cycle")

endmodule
